[src/pcgbg_pkg.sv]
// ----------------------------------------------------------------------------
// pcgbg_pkg
// Shared types and constants for the PCG32 bounded generator: payload structs,
// action and status codes, and the controller to datapath command set.
// ----------------------------------------------------------------------------
package pcgbg_pkg;

  localparam logic [63:0] PCG_MULT   = 64'd6364136223846793005;
  localparam logic [63:0] PCG_STREAM = 64'h004d_415a_455f_5631;
  localparam logic [63:0] PCG_INC    = {PCG_STREAM[62:0], 1'b1};
  // State after a reseed with a zero seed.
  localparam logic [63:0] LCG_RESET  = PCG_INC * PCG_MULT + PCG_INC;

  localparam int unsigned XS_SHIFT_A = 18;
  localparam int unsigned XS_SHIFT_B = 27;
  localparam int unsigned ROT_LSB    = 59;

  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    ACT_RAW     = 2'd0,
    ACT_BOUNDED = 2'd1,
    ACT_STEP    = 2'd2,
    ACT_RESEED  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_CANCELLED = 2'd1,
    ST_LIMIT     = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEED_VALUE = 2'd0,
    REG_STEP_LIMIT = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] bound;
    logic        cancel_request;
  } in_item_t;

  typedef struct packed {
    logic [31:0] random_value;
    logic [1:0]  status;
    logic [63:0] steps_taken;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_LIMIT,
    OP_DIV_VALUE,
    OP_DIV_STEP,
    OP_SAVE_LIMIT,
    OP_SAVE_VALUE,
    OP_DRAW,
    OP_RESEED,
    OP_MUL_LL,
    OP_MUL_LH,
    OP_MUL_HL,
    OP_LCG_WRITE,
    OP_STEP,
    OP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    action_e action;
    logic    bound_zero;
    logic    accept;
    logic    out_busy;
  } dp_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_LIM_DIV,
    S_LIM_SAVE,
    S_DRAW,
    S_RESEED,
    S_MUL_LL,
    S_MUL_LH,
    S_MUL_HL,
    S_LCG_WR,
    S_CHECK,
    S_VAL_DIV,
    S_VAL_SAVE,
    S_STEP,
    S_OUT
  } ctrl_state_e;

endpackage

[src/pcgbg_dp.sv]
// ----------------------------------------------------------------------------
// pcgbg_dp
// Datapath: generator state, step counter, configuration registers, a shared
// 32x32 multiplier for the LCG update, a radix-2 remainder unit and the
// output register.
// ----------------------------------------------------------------------------
module pcgbg_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pcgbg_pkg::dp_cmd_t             cmd_i,
  output pcgbg_pkg::dp_status_t          status_o,
  input  pcgbg_pkg::in_item_t            in_data_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output pcgbg_pkg::out_item_t           out_data_o,
  input  logic                           cfg_we_i,
  input  logic [pcgbg_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [63:0]                    cfg_wdata_i
);

  logic [63:0] lcg_q, lcg_d;
  logic [63:0] count_q, count_d;
  logic [63:0] seed_q, limit_q;
  logic [63:0] src_q, src_d;
  logic [63:0] acc_q, acc_d;
  logic [1:0]  action_q, action_d;
  logic [31:0] bound_q, bound_d;
  logic        cancel_q, cancel_d;
  logic [31:0] value_q, value_d;
  logic [1:0]  stat_q, stat_d;
  logic [31:0] thr_q, thr_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] dvd_q, dvd_d;
  logic        out_valid_q, out_valid_d;
  pcgbg_pkg::out_item_t out_q, out_d;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [32:0] shifted;
  logic [31:0] drawn;

  function automatic logic [31:0] pcg_output(input logic [63:0] old);
    logic [31:0] xs;
    logic [4:0]  rot;
    logic [63:0] dbl;
    xs  = 32'((((old >> pcgbg_pkg::XS_SHIFT_A) ^ old) >> pcgbg_pkg::XS_SHIFT_B));
    rot = old[63:pcgbg_pkg::ROT_LSB];
    dbl = {xs, xs} >> rot;
    return dbl[31:0];
  endfunction

  assign drawn = pcg_output(lcg_q);

  always_comb begin
    mul_a = src_q[31:0];
    mul_b = pcgbg_pkg::PCG_MULT[31:0];
    case (cmd_i.op)
      pcgbg_pkg::OP_MUL_LH: mul_b = pcgbg_pkg::PCG_MULT[63:32];
      pcgbg_pkg::OP_MUL_HL: mul_a = src_q[63:32];
      default: ;
    endcase
    prod = 64'(mul_a) * 64'(mul_b);
  end

  assign shifted = {rem_q, dvd_q[31]};

  always_comb begin
    lcg_d       = lcg_q;
    count_d     = count_q;
    src_d       = src_q;
    acc_d       = acc_q;
    action_d    = action_q;
    bound_d     = bound_q;
    cancel_d    = cancel_q;
    value_d     = value_q;
    stat_d      = stat_q;
    thr_d       = thr_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (cmd_i.op)
      pcgbg_pkg::OP_LOAD: begin
        action_d = in_data_i.action;
        bound_d  = in_data_i.bound;
        cancel_d = in_data_i.cancel_request;
        value_d  = '0;
        stat_d   = pcgbg_pkg::ST_OK;
      end
      pcgbg_pkg::OP_DIV_LIMIT: begin
        rem_d = '0;
        dvd_d = 32'd0 - bound_q;
      end
      pcgbg_pkg::OP_DIV_VALUE: begin
        rem_d = '0;
        dvd_d = value_q;
      end
      pcgbg_pkg::OP_DIV_STEP: begin
        if (shifted >= {1'b0, bound_q}) begin
          rem_d = 32'(shifted - {1'b0, bound_q});
        end else begin
          rem_d = shifted[31:0];
        end
        dvd_d = {dvd_q[30:0], 1'b0};
      end
      pcgbg_pkg::OP_SAVE_LIMIT: thr_d = rem_q;
      pcgbg_pkg::OP_SAVE_VALUE: value_d = rem_q;
      pcgbg_pkg::OP_DRAW: begin
        src_d   = lcg_q;
        value_d = drawn;
      end
      pcgbg_pkg::OP_RESEED: src_d = pcgbg_pkg::PCG_INC + seed_q;
      pcgbg_pkg::OP_MUL_LL: acc_d = prod;
      pcgbg_pkg::OP_MUL_LH,
      pcgbg_pkg::OP_MUL_HL: acc_d = {acc_q[63:32] + prod[31:0], acc_q[31:0]};
      pcgbg_pkg::OP_LCG_WRITE: lcg_d = acc_q + pcgbg_pkg::PCG_INC;
      pcgbg_pkg::OP_STEP: begin
        if (cancel_q) begin
          stat_d = pcgbg_pkg::ST_CANCELLED;
        end else if (limit_q != '0 && count_q >= limit_q) begin
          stat_d = pcgbg_pkg::ST_LIMIT;
        end else begin
          count_d = count_q + 64'd1;
        end
      end
      pcgbg_pkg::OP_OUT: begin
        out_d.random_value = value_q;
        out_d.status       = stat_q;
        out_d.steps_taken  = count_q;
        out_valid_d        = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcg_q       <= pcgbg_pkg::LCG_RESET;
      count_q     <= '0;
      seed_q      <= '0;
      limit_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      lcg_q       <= lcg_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          pcgbg_pkg::REG_SEED_VALUE: seed_q  <= cfg_wdata_i;
          pcgbg_pkg::REG_STEP_LIMIT: limit_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    src_q    <= src_d;
    acc_q    <= acc_d;
    action_q <= action_d;
    bound_q  <= bound_d;
    cancel_q <= cancel_d;
    value_q  <= value_d;
    stat_q   <= stat_d;
    thr_q    <= thr_d;
    rem_q    <= rem_d;
    dvd_q    <= dvd_d;
    out_q    <= out_d;
  end

  assign status_o.action     = pcgbg_pkg::action_e'(action_q);
  assign status_o.bound_zero = (bound_q == '0);
  assign status_o.accept     = (value_q >= thr_q);
  assign status_o.out_busy   = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[src/pcgbg_ctrl.sv]
// ----------------------------------------------------------------------------
// pcgbg_ctrl
// Controller: sequences each item through decode, remainder iterations,
// multiply steps of the LCG update, rejection checks and the result handoff.
// ----------------------------------------------------------------------------
module pcgbg_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pcgbg_pkg::dp_status_t status_i,
  output pcgbg_pkg::dp_cmd_t    cmd_o
);

  pcgbg_pkg::ctrl_state_e state_q, state_d;
  logic [pcgbg_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic div_last;

  assign div_last = (cnt_q == pcgbg_pkg::CNT_W'(pcgbg_pkg::DIV_STEPS - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pcgbg_pkg::S_IDLE:     if (in_valid_i) state_d = pcgbg_pkg::S_DECODE;
      pcgbg_pkg::S_DECODE: begin
        unique case (status_i.action)
          pcgbg_pkg::ACT_RAW:     state_d = pcgbg_pkg::S_DRAW;
          pcgbg_pkg::ACT_BOUNDED: state_d = status_i.bound_zero ? pcgbg_pkg::S_OUT
                                                                : pcgbg_pkg::S_LIM_DIV;
          pcgbg_pkg::ACT_STEP:    state_d = pcgbg_pkg::S_STEP;
          pcgbg_pkg::ACT_RESEED:  state_d = pcgbg_pkg::S_RESEED;
          default:                state_d = pcgbg_pkg::S_OUT;
        endcase
      end
      pcgbg_pkg::S_LIM_DIV:  if (div_last) state_d = pcgbg_pkg::S_LIM_SAVE;
      pcgbg_pkg::S_LIM_SAVE: state_d = pcgbg_pkg::S_DRAW;
      pcgbg_pkg::S_DRAW:     state_d = pcgbg_pkg::S_MUL_LL;
      pcgbg_pkg::S_RESEED:   state_d = pcgbg_pkg::S_MUL_LL;
      pcgbg_pkg::S_MUL_LL:   state_d = pcgbg_pkg::S_MUL_LH;
      pcgbg_pkg::S_MUL_LH:   state_d = pcgbg_pkg::S_MUL_HL;
      pcgbg_pkg::S_MUL_HL:   state_d = pcgbg_pkg::S_LCG_WR;
      pcgbg_pkg::S_LCG_WR:   state_d = (status_i.action == pcgbg_pkg::ACT_BOUNDED)
                                       ? pcgbg_pkg::S_CHECK : pcgbg_pkg::S_OUT;
      pcgbg_pkg::S_CHECK:    state_d = status_i.accept ? pcgbg_pkg::S_VAL_DIV
                                                       : pcgbg_pkg::S_DRAW;
      pcgbg_pkg::S_VAL_DIV:  if (div_last) state_d = pcgbg_pkg::S_VAL_SAVE;
      pcgbg_pkg::S_VAL_SAVE: state_d = pcgbg_pkg::S_OUT;
      pcgbg_pkg::S_STEP:     state_d = pcgbg_pkg::S_OUT;
      pcgbg_pkg::S_OUT:      if (!status_i.out_busy) state_d = pcgbg_pkg::S_IDLE;
      default:               state_d = pcgbg_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op   = pcgbg_pkg::OP_NONE;
    in_ready_o = 1'b0;
    cnt_d      = '0;
    unique case (state_q)
      pcgbg_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = pcgbg_pkg::OP_LOAD;
      end
      pcgbg_pkg::S_DECODE:   cmd_o.op = pcgbg_pkg::OP_DIV_LIMIT;
      pcgbg_pkg::S_LIM_DIV,
      pcgbg_pkg::S_VAL_DIV: begin
        cmd_o.op = pcgbg_pkg::OP_DIV_STEP;
        cnt_d    = cnt_q + 1'b1;
      end
      pcgbg_pkg::S_LIM_SAVE: cmd_o.op = pcgbg_pkg::OP_SAVE_LIMIT;
      pcgbg_pkg::S_DRAW:     cmd_o.op = pcgbg_pkg::OP_DRAW;
      pcgbg_pkg::S_RESEED:   cmd_o.op = pcgbg_pkg::OP_RESEED;
      pcgbg_pkg::S_MUL_LL:   cmd_o.op = pcgbg_pkg::OP_MUL_LL;
      pcgbg_pkg::S_MUL_LH:   cmd_o.op = pcgbg_pkg::OP_MUL_LH;
      pcgbg_pkg::S_MUL_HL:   cmd_o.op = pcgbg_pkg::OP_MUL_HL;
      pcgbg_pkg::S_LCG_WR:   cmd_o.op = pcgbg_pkg::OP_LCG_WRITE;
      pcgbg_pkg::S_CHECK:    if (status_i.accept) cmd_o.op = pcgbg_pkg::OP_DIV_VALUE;
      pcgbg_pkg::S_VAL_SAVE: cmd_o.op = pcgbg_pkg::OP_SAVE_VALUE;
      pcgbg_pkg::S_STEP:     cmd_o.op = pcgbg_pkg::OP_STEP;
      pcgbg_pkg::S_OUT:      if (!status_i.out_busy) cmd_o.op = pcgbg_pkg::OP_OUT;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcgbg_pkg::S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

[src/pcg32_bounded_generator.sv]
// ----------------------------------------------------------------------------
// pcg32_bounded_generator
// PCG32 XSH-RR generator with raw and bounded draws, reseed and a step governor.
// ----------------------------------------------------------------------------
// Usage: each item on the input channel carries an action, a bound and a
// cancel flag; exactly one result item comes back per input item, in order.
// Configuration writes (seed value, step limit) take effect at once; they must
// be made while the block is idle, which the block itself does not enforce.
// After an item is accepted, a raw draw runs decode, draw, the LCG update and
// handoff; a reseed likewise with a reseed step for the draw; a step runs
// decode, step and handoff; a zero-bound draw runs decode and handoff.
// Other bounded draws run a 32-step remainder for the rejection threshold,
// draws with a check until one is accepted, then another of the accepted
// value. The LCG update is three multiply steps on one 32x32 multiplier and a
// state write; the remainder unit retires one quotient bit per cycle. Items
// are handled one at a time; a new item is accepted as soon as the previous
// result sits in the output register, even while it waits there. When the
// receiver stalls, the result holds and the next item parks before its
// handoff. Reset loads the generator state of a zero-seed reseed, clears the
// step count and both configuration registers, and empties the output.
// ----------------------------------------------------------------------------
module pcg32_bounded_generator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  pcgbg_pkg::in_item_t             in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output pcgbg_pkg::out_item_t            out_data_o,
  input  logic                            cfg_we_i,
  input  logic [pcgbg_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [63:0]                     cfg_wdata_i
);

  pcgbg_pkg::dp_cmd_t    cmd;
  pcgbg_pkg::dp_status_t dp_status;

  pcgbg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  pcgbg_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (dp_status),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

endmodule

[src/pcgbg_checker.sv]
// ----------------------------------------------------------------------------
// pcgbg_checker
// Port-level checks on the generator's channels, bound to the top level.
// ----------------------------------------------------------------------------
module pcgbg_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input pcgbg_pkg::out_item_t out_data_o
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // The block works on one item at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after an accepted item");

  // No result can appear in the cycle right after an item is taken.
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared too early");

  // Only draws return a value, and draws always report ok.
  a_value_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.random_value != '0 |->
      out_data_o.status == pcgbg_pkg::ST_OK)
    else $error("nonzero value with non-ok status");

endmodule

bind pcg32_bounded_generator pcgbg_checker u_checker (.*);

[test/pcg32_bounded_generator_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pcg32_bounded_generator_tb
// Self-checking testbench for the PCG32 bounded generator. A queue of request
// items feeds a valid/ready driver, and a monitor checks every result item
// against a predictor that keeps its own generator state, step count and
// register copies. Directed cases come first, then random phases under
// several register settings with random idling on both sides, a long
// receiver stall and sender pauses.
// ----------------------------------------------------------------------------
module pcg32_bounded_generator_tb;

  localparam logic [pcgbg_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_LO = 2'd2;
  localparam logic [pcgbg_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_HI = 2'd3;
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned PHASE_ITEMS = 200;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            in_valid_i = 1'b0;
  logic                            in_ready_o;
  pcgbg_pkg::in_item_t             in_data_i = '0;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  pcgbg_pkg::out_item_t            out_data_o;
  logic                            cfg_we_i = 1'b0;
  logic [pcgbg_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [63:0]                     cfg_wdata_i = '0;

  // Predictor state.
  logic [63:0] gen_state;
  logic [63:0] granted_steps;
  logic [63:0] seed_reg;
  logic [63:0] limit_reg;

  pcgbg_pkg::in_item_t  request_queue[$];
  pcgbg_pkg::out_item_t pending_replies[$];
  int unsigned items_issued = 0;
  int unsigned results_seen = 0;
  int unsigned error_count = 0;
  int unsigned send_gap = 0;
  int unsigned hold_left = 0;
  int unsigned stall_token = 0;
  int unsigned stall_seen = 0;
  logic        sender_gaps_on = 1'b0;
  logic        receiver_gaps_on = 1'b0;

  pcg32_bounded_generator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [31:0] next_word();
    logic [63:0] prior;
    logic [31:0] xs;
    logic [63:0] twice;
    prior = gen_state;
    gen_state = prior * pcgbg_pkg::PCG_MULT + pcgbg_pkg::PCG_INC;
    xs = 32'(((prior >> pcgbg_pkg::XS_SHIFT_A) ^ prior) >> pcgbg_pkg::XS_SHIFT_B);
    twice = {xs, xs} >> prior[63:pcgbg_pkg::ROT_LSB];
    return twice[31:0];
  endfunction

  function automatic logic [31:0] bounded_word(logic [31:0] bound);
    logic [31:0] floor_v;
    logic [31:0] v;
    if (bound == 32'd0) begin
      return 32'd0;
    end
    floor_v = (32'd0 - bound) % bound;
    do begin
      v = next_word();
    end while (v < floor_v);
    return v % bound;
  endfunction

  function automatic void reseed_generator();
    gen_state = 64'd0;
    void'(next_word());
    gen_state = gen_state + seed_reg;
    void'(next_word());
  endfunction

  function automatic pcgbg_pkg::out_item_t compute_generator_reply(
      pcgbg_pkg::in_item_t req);
    pcgbg_pkg::out_item_t rsp;
    rsp = '0;
    rsp.status = pcgbg_pkg::ST_OK;
    case (req.action)
      pcgbg_pkg::ACT_RAW: begin
        rsp.random_value = next_word();
      end
      pcgbg_pkg::ACT_BOUNDED: begin
        rsp.random_value = bounded_word(req.bound);
      end
      pcgbg_pkg::ACT_STEP: begin
        if (req.cancel_request) begin
          rsp.status = pcgbg_pkg::ST_CANCELLED;
        end else if (limit_reg != 64'd0 && granted_steps >= limit_reg) begin
          rsp.status = pcgbg_pkg::ST_LIMIT;
        end else begin
          granted_steps = granted_steps + 64'd1;
        end
      end
      default: begin
        reseed_generator();
      end
    endcase
    rsp.steps_taken = granted_steps;
    return rsp;
  endfunction

  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] pick_bound();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      return $urandom_range(0, 16);
    end else if (r < 40) begin
      case ($urandom_range(0, 4))
        0: return 32'd0;
        1: return 32'd1;
        2: return 32'hFFFF_FFFF;
        3: return 32'h8000_0000;
        default: return 32'h8000_0001;
      endcase
    end
    return $urandom;
  endfunction

  function automatic pcgbg_pkg::in_item_t random_request();
    pcgbg_pkg::in_item_t req;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      req.action = pcgbg_pkg::ACT_RAW;
    end else if (r < 55) begin
      req.action = pcgbg_pkg::ACT_BOUNDED;
    end else if (r < 90) begin
      req.action = pcgbg_pkg::ACT_STEP;
    end else begin
      req.action = pcgbg_pkg::ACT_RESEED;
    end
    req.bound = pick_bound();
    req.cancel_request = ($urandom_range(0, 9) < 3);
    return req;
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < 100) begin
      $display("%0t: mismatch: %s", $time, msg);
    end
    error_count++;
  endtask

  task automatic check_reply(input pcgbg_pkg::out_item_t got);
    pcgbg_pkg::out_item_t want;
    if (pending_replies.size() == 0) begin
      report_mismatch($sformatf("result %h with no item outstanding", got));
      return;
    end
    want = pending_replies.pop_front();
    if (got.random_value !== want.random_value) begin
      report_mismatch($sformatf("random_value %h, expected %h",
                                got.random_value, want.random_value));
    end
    if (got.status !== want.status) begin
      report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
    end
    if (got.steps_taken !== want.steps_taken) begin
      report_mismatch($sformatf("steps_taken %0d, expected %0d",
                                got.steps_taken, want.steps_taken));
    end
  endtask

  // Request driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      send_gap = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        pending_replies.push_back(compute_generator_reply(in_data_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (request_queue.size() != 0) begin
          in_valid_i <= 1'b1;
          in_data_i  <= request_queue.pop_front();
          if (sender_gaps_on) begin
            send_gap = idle_length();
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left = 0;
      stall_seen = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        check_reply(out_data_o);
        results_seen++;
      end
      if (stall_token != stall_seen) begin
        stall_seen = stall_token;
        hold_left = LONG_HOLD;
      end else if (hold_left == 0 && receiver_gaps_on && $urandom_range(0, 3) == 0) begin
        hold_left = idle_length();
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic queue_request(input pcgbg_pkg::action_e act, input logic [31:0] bound,
                               input logic cancel);
    pcgbg_pkg::in_item_t req;
    req.action = act;
    req.bound = bound;
    req.cancel_request = cancel;
    request_queue.push_back(req);
    items_issued++;
  endtask

  task automatic queue_random(input int unsigned count);
    repeat (count) begin
      request_queue.push_back(random_request());
      items_issued++;
    end
  endtask

  task automatic write_register(input logic [pcgbg_pkg::CFG_IDX_W-1:0] idx,
                                input logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      pcgbg_pkg::REG_SEED_VALUE: seed_reg = val;
      pcgbg_pkg::REG_STEP_LIMIT: limit_reg = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    do begin
      @(negedge clk_i);
    end while (results_seen != items_issued);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [63:0] pick_seed();
    case ($urandom_range(0, 3))
      0: return 64'd0;
      1: return 64'hFFFF_FFFF_FFFF_FFFF;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [63:0] pick_limit();
    case ($urandom_range(0, 5))
      0: return 64'd0;
      1: return 64'hFFFF_FFFF_FFFF_FFFF;
      2: return 64'd1;
      3: return {$urandom, $urandom};
      default: return granted_steps + $urandom_range(0, 20);
    endcase
  endfunction

  initial begin
    seed_reg = 64'd0;
    limit_reg = 64'd0;
    granted_steps = 64'd0;
    reseed_generator();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: zero seed and no step limit.
    sender_gaps_on   <= 1'b1;
    receiver_gaps_on <= 1'b1;
    queue_request(pcgbg_pkg::ACT_RAW, 32'd0, 1'b0);
    queue_request(pcgbg_pkg::ACT_RAW, 32'hFFFF_FFFF, 1'b1);
    queue_request(pcgbg_pkg::ACT_BOUNDED, 32'd0, 1'b0);
    queue_request(pcgbg_pkg::ACT_BOUNDED, 32'd1, 1'b1);
    queue_request(pcgbg_pkg::ACT_BOUNDED, 32'd2, 1'b0);
    queue_request(pcgbg_pkg::ACT_BOUNDED, 32'd3, 1'b0);
    queue_request(pcgbg_pkg::ACT_BOUNDED, 32'hFFFF_FFFF, 1'b0);
    queue_request(pcgbg_pkg::ACT_BOUNDED, 32'h8000_0000, 1'b0);
    queue_request(pcgbg_pkg::ACT_BOUNDED, 32'h8000_0001, 1'b0);
    queue_request(pcgbg_pkg::ACT_STEP, 32'd0, 1'b0);
    queue_request(pcgbg_pkg::ACT_STEP, 32'd0, 1'b1);
    queue_request(pcgbg_pkg::ACT_STEP, 32'hFFFF_FFFF, 1'b0);
    queue_request(pcgbg_pkg::ACT_RESEED, 32'hFFFF_FFFF, 1'b1);
    queue_request(pcgbg_pkg::ACT_RAW, 32'd5, 1'b0);
    wait_drained();

    write_register(pcgbg_pkg::REG_SEED_VALUE, 64'hFFFF_FFFF_FFFF_FFFF);
    write_register(pcgbg_pkg::REG_STEP_LIMIT, 64'd3);
    queue_request(pcgbg_pkg::ACT_RESEED, 32'd0, 1'b0);
    queue_request(pcgbg_pkg::ACT_RAW, 32'd0, 1'b0);
    queue_request(pcgbg_pkg::ACT_STEP, 32'd0, 1'b0);
    queue_request(pcgbg_pkg::ACT_STEP, 32'd0, 1'b0);
    queue_request(pcgbg_pkg::ACT_STEP, 32'd0, 1'b1);
    queue_request(pcgbg_pkg::ACT_BOUNDED, 32'd7, 1'b1);
    wait_drained();

    // Writes to unmapped indexes must leave both registers alone.
    write_register(REG_UNMAPPED_LO, 64'hFFFF_FFFF_FFFF_FFFF);
    write_register(REG_UNMAPPED_HI, 64'd0);
    queue_request(pcgbg_pkg::ACT_STEP, 32'd0, 1'b0);
    queue_request(pcgbg_pkg::ACT_RESEED, 32'd0, 1'b0);
    wait_drained();

    write_register(pcgbg_pkg::REG_STEP_LIMIT, 64'hFFFF_FFFF_FFFF_FFFF);
    write_register(pcgbg_pkg::REG_SEED_VALUE, 64'd0);
    queue_request(pcgbg_pkg::ACT_STEP, 32'd0, 1'b0);
    queue_request(pcgbg_pkg::ACT_RESEED, 32'd0, 1'b0);
    queue_request(pcgbg_pkg::ACT_RAW, 32'd0, 1'b0);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      if (p == 0) begin
        write_register(pcgbg_pkg::REG_SEED_VALUE, 64'hFFFF_FFFF_FFFF_FFFF);
        write_register(pcgbg_pkg::REG_STEP_LIMIT, 64'd0);
      end else if (p == 7) begin
        write_register(pcgbg_pkg::REG_SEED_VALUE, 64'd0);
        write_register(pcgbg_pkg::REG_STEP_LIMIT, 64'hFFFF_FFFF_FFFF_FFFF);
      end else begin
        write_register(pcgbg_pkg::REG_SEED_VALUE, pick_seed());
        write_register(pcgbg_pkg::REG_STEP_LIMIT, pick_limit());
      end
      sender_gaps_on   <= (p != 1 && p != 4 && p != 6);
      receiver_gaps_on <= (p != 1 && p != 5);
      @(posedge clk_i);
      if (p == 4) begin
        // The receiver holds off while the sender keeps offering items.
        stall_token <= stall_token + 1;
        queue_random(40);
        wait_drained();
        sender_gaps_on <= 1'b1;
        queue_random(PHASE_ITEMS - 40);
      end else if (p == 2 || p == 7) begin
        queue_random(PHASE_ITEMS / 2);
        wait_drained();
        queue_random(PHASE_ITEMS / 2);
      end else begin
        queue_random(PHASE_ITEMS);
      end
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (pending_replies.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_replies.size()));
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
